// ===== rtl/cca_pkg.sv =====
// Shared types, constants and calendar tables for the calendar clock core.
package cca_pkg;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_SET     = 1'b1;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;

    localparam int DAYS_W = 17;
    localparam int HMS_W  = 17;

    typedef struct packed {
        logic load_set;
        logic load_adv;
        logic do_day;
        logic do_hour;
        logic do_min;
        logic do_sec;
        logic calc_days;
        logic calc_mul;
        logic calc_sum;
    } cca_cmd_t;

    typedef struct packed {
        logic ge_day;
        logic ge_hour;
        logic ge_min;
        logic nz;
    } cca_stat_t;

    // Length of a month; unknown month codes count as 30 days.
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mo);
        logic [4:0] len;
        begin
            case (mo)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd2: len = leap ? 5'd29 : 5'd28;
                default: len = 5'd30;
            endcase
            return len;
        end
    endfunction

    // Days in the months before mo, months 13 and 14 taken as 30 days.
    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] mo);
        logic [8:0] d;
        logic [8:0] adj;
        begin
            adj = (leap && (mo >= 4'd3)) ? 9'd1 : 9'd0;
            case (mo)
                4'd0, 4'd1: d = 9'd0;
                4'd2:  d = 9'd31;
                4'd3:  d = 9'd59;
                4'd4:  d = 9'd90;
                4'd5:  d = 9'd120;
                4'd6:  d = 9'd151;
                4'd7:  d = 9'd181;
                4'd8:  d = 9'd212;
                4'd9:  d = 9'd243;
                4'd10: d = 9'd273;
                4'd11: d = 9'd304;
                4'd12: d = 9'd334;
                4'd13: d = 9'd365;
                4'd14: d = 9'd395;
                4'd15: d = 9'd425;
                default: d = 9'd0;
            endcase
            return d + adj;
        end
    endfunction

endpackage

// ===== rtl/cca_dp.sv =====
// Datapath: date registers, carry chain, seconds countdown and timestamp arithmetic.
module cca_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  cca_pkg::cca_cmd_t   ctl,
    output cca_pkg::cca_stat_t  stat,
    input  logic [31:0]         delta_seconds,
    input  logic [7:0]          set_year,
    input  logic [3:0]          set_month,
    input  logic [4:0]          set_day,
    input  logic [4:0]          set_hour,
    input  logic [5:0]          set_minute,
    input  logic [5:0]          set_second,
    output logic [7:0]          year_out,
    output logic [3:0]          month_out,
    output logic [4:0]          day_out,
    output logic [4:0]          hour_out,
    output logic [5:0]          minute_out,
    output logic [5:0]          second_out,
    output logic [31:0]         timestamp
);
    import cca_pkg::*;

    logic [7:0]  year_reg,   year_next;
    logic [3:0]  month_reg,  month_next;
    logic [4:0]  day_reg,    day_next;
    logic [4:0]  hour_reg,   hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [31:0] left_reg,   left_next;

    logic [DAYS_W-1:0] days_reg, days_next;
    logic [HMS_W-1:0]  hms_reg,  hms_next;
    logic [31:0]       prod_reg, prod_next;
    logic [31:0]       ts_reg,   ts_next;

    logic sec_wrap, min_wrap, hour_wrap, day_end, leap;
    logic sec_step, min_step, hour_step, day_step;
    logic [5:0] yq;

    assign leap      = (year_reg[1:0] == 2'b00);
    assign sec_wrap  = (second_reg >= 6'd59);
    assign min_wrap  = (minute_reg >= 6'd59);
    assign hour_wrap = (hour_reg >= 5'd23);
    assign day_end   = (day_reg >= month_len(leap, month_reg));

    assign sec_step  = ctl.do_sec;
    assign min_step  = ctl.do_min  | (sec_step & sec_wrap);
    assign hour_step = ctl.do_hour | (min_step & min_wrap);
    assign day_step  = ctl.do_day  | (hour_step & hour_wrap);

    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (ctl.load_set)
        begin
            year_next   = set_year;
            month_next  = set_month;
            day_next    = set_day;
            hour_next   = set_hour;
            minute_next = set_minute;
            second_next = set_second;
        end
        else
        begin
            if (sec_step)
                second_next = sec_wrap ? 6'd0 : second_reg + 6'd1;
            if (min_step)
                minute_next = min_wrap ? 6'd0 : minute_reg + 6'd1;
            if (hour_step)
                hour_next = hour_wrap ? 5'd0 : hour_reg + 5'd1;
            if (day_step)
            begin
                if (!day_end)
                    day_next = day_reg + 5'd1;
                else
                begin
                    day_next = 5'd1;
                    if (month_reg < 4'd12)
                        month_next = month_reg + 4'd1;
                    else
                    begin
                        month_next = 4'd1;
                        year_next  = year_reg + 8'd1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        left_next = left_reg;
        if (ctl.load_adv)
            left_next = delta_seconds;
        else if (ctl.do_day)
            left_next = left_reg - SECS_PER_DAY;
        else if (ctl.do_hour)
            left_next = left_reg - SECS_PER_HOUR;
        else if (ctl.do_min)
            left_next = left_reg - SECS_PER_MIN;
        else if (ctl.do_sec)
            left_next = left_reg - 32'd1;
    end

    assign stat.ge_day  = (left_reg >= SECS_PER_DAY);
    assign stat.ge_hour = (left_reg >= SECS_PER_HOUR);
    assign stat.ge_min  = (left_reg >= SECS_PER_MIN);
    assign stat.nz      = |left_reg;

    // Day count: the +1 base day and the day-1 term cancel.
    always_comb
    begin
        yq = (year_reg == 8'd0) ? 6'd0 : 6'((year_reg - 8'd1) >> 2);
        days_next = DAYS_W'(year_reg) * DAYS_W'(365) + DAYS_W'(yq)
                  + DAYS_W'(cum_days(leap, month_reg)) + DAYS_W'(day_reg);
        hms_next  = HMS_W'(hour_reg) * HMS_W'(3600) + HMS_W'(minute_reg) * HMS_W'(60)
                  + HMS_W'(second_reg);
        prod_next = 32'(days_reg) * SECS_PER_DAY;
        ts_next   = prod_reg + 32'(hms_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg   <= 8'd0;
            month_reg  <= 4'd1;
            day_reg    <= 5'd1;
            hour_reg   <= 5'd0;
            minute_reg <= 6'd0;
            second_reg <= 6'd0;
        end
        else
        begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        if (ctl.calc_days)
        begin
            days_reg <= days_next;
            hms_reg  <= hms_next;
        end
        if (ctl.calc_mul)
            prod_reg <= prod_next;
        if (ctl.calc_sum)
            ts_reg <= ts_next;
    end

    assign year_out   = year_reg;
    assign month_out  = month_reg;
    assign day_out    = day_reg;
    assign hour_out   = hour_reg;
    assign minute_out = minute_reg;
    assign second_out = second_reg;
    assign timestamp  = ts_reg;

endmodule

// ===== rtl/cca_ctrl.sv =====
// Controller: sequences load, day/hour/minute/second stepping and the timestamp stages.
module cca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    input  cca_pkg::cca_stat_t  stat,
    output cca_pkg::cca_cmd_t   ctl,
    output logic                busy,
    output logic                done
);
    import cca_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DAY  = 8'b0000_0010,
        S_HOUR = 8'b0000_0100,
        S_MIN  = 8'b0000_1000,
        S_SEC  = 8'b0001_0000,
        S_DAYS = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_SUM  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_SET)
                    begin
                        ctl.load_set = 1'b1;
                        state_next   = S_DAYS;
                    end
                    else
                    begin
                        ctl.load_adv = 1'b1;
                        state_next   = S_DAY;
                    end
                end
            end
            S_DAY:
            begin
                if (stat.ge_day)
                    ctl.do_day = 1'b1;
                else
                    state_next = S_HOUR;
            end
            S_HOUR:
            begin
                if (stat.ge_hour)
                    ctl.do_hour = 1'b1;
                else
                    state_next = S_MIN;
            end
            S_MIN:
            begin
                if (stat.ge_min)
                    ctl.do_min = 1'b1;
                else
                    state_next = S_SEC;
            end
            S_SEC:
            begin
                if (stat.nz)
                    ctl.do_sec = 1'b1;
                else
                    state_next = S_DAYS;
            end
            S_DAYS:
            begin
                ctl.calc_days = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                ctl.calc_mul = 1'b1;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                ctl.calc_sum = 1'b1;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== rtl/calendar_clock_advance_core.sv =====
// Top level of the calendar clock core: controller plus datapath.
//
//  channel   | handshake        | payload
//  ----------+------------------+---------------------------------------------
//  command   | start / busy     | cmd, delta_seconds, set_year .. set_second
//  result    | done (strobe)    | year_out .. second_out, timestamp
//
// A set transaction loads the date, then passes the day count, multiply and sum
// states before done. An advance steps the days, hours, minutes and seconds of
// delta_seconds in turn; the seconds countdown steps one unit a cycle.
// Reset gives 00-01-01 00:00:00. The result strobe lasts one cycle, with busy
// already low, so a new transaction may be accepted on that same edge.
module calendar_clock_advance_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cmd,
    input  logic [31:0] delta_seconds,
    input  logic [7:0]  set_year,
    input  logic [3:0]  set_month,
    input  logic [4:0]  set_day,
    input  logic [4:0]  set_hour,
    input  logic [5:0]  set_minute,
    input  logic [5:0]  set_second,
    output logic [7:0]  year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [5:0]  second_out,
    output logic [31:0] timestamp
);
    import cca_pkg::*;

    cca_cmd_t  ctl;
    cca_stat_t stat;

    cca_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    cca_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .delta_seconds (delta_seconds),
        .set_year      (set_year),
        .set_month     (set_month),
        .set_day       (set_day),
        .set_hour      (set_hour),
        .set_minute    (set_minute),
        .set_second    (set_second),
        .year_out      (year_out),
        .month_out     (month_out),
        .day_out       (day_out),
        .hour_out      (hour_out),
        .minute_out    (minute_out),
        .second_out    (second_out),
        .timestamp     (timestamp)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    a_set_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_SET) |=>
            (year_out == $past(set_year) && month_out == $past(set_month)
             && day_out == $past(set_day) && second_out == $past(set_second)))
        else $error("set transaction did not load the date");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the calendar clock core: set and advance transactions.
`timescale 1ns / 1ps

module testbench;
    import cca_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [31:0] delta;
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_txn_t;

    typedef struct packed {
        logic [7:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] stamp;
    } date_rec_t;

    typedef struct packed {
        cal_txn_t  txn;
        logic      typed;
        date_rec_t want;
    } dir_row_t;

    localparam date_rec_t RESET_DATE = '{8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd86400};
    localparam date_rec_t ZERO_DATE  = '{8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0};
    localparam int RANDOM_ITEMS  = 400;
    localparam int MAX_BIG_JUMPS = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        cmd;
    logic [31:0] delta_seconds;
    logic [7:0]  set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic [7:0]  year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [31:0] timestamp;

    // predicted calendar state
    logic [7:0] cal_year;
    logic [3:0] cal_month;
    logic [4:0] cal_day;
    logic [4:0] cal_hour;
    logic [5:0] cal_minute;
    logic [5:0] cal_second;

    date_rec_t   expected_dates[$];
    int          mismatches = 0;
    int          big_jumps  = 0;
    int unsigned delta_edges[6] = '{59, 60, 3599, 3600, 86399, 86400};

    calendar_clock_advance_core i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [4:0] month_days(logic [7:0] yr, logic [3:0] mo);
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
            4'd2: return (yr[1:0] != 2'b00) ? 5'd28 : 5'd29;
            default: return 5'd30;
        endcase
    endfunction

    function automatic void calendar_day_step();
        if (cal_day < month_days(cal_year, cal_month))
        begin
            cal_day = cal_day + 5'd1;
        end
        else
        begin
            cal_day = 5'd1;
            if (cal_month < 4'd12)
            begin
                cal_month = cal_month + 4'd1;
            end
            else
            begin
                cal_month = 4'd1;
                cal_year  = cal_year + 8'd1;
            end
        end
    endfunction

    function automatic void calendar_hour_step();
        if (cal_hour < 5'd23)
        begin
            cal_hour = cal_hour + 5'd1;
        end
        else
        begin
            cal_hour = 5'd0;
            calendar_day_step();
        end
    endfunction

    function automatic void calendar_minute_step();
        if (cal_minute < 6'd59)
        begin
            cal_minute = cal_minute + 6'd1;
        end
        else
        begin
            cal_minute = 6'd0;
            calendar_hour_step();
        end
    endfunction

    function automatic void calendar_second_step();
        if (cal_second < 6'd59)
        begin
            cal_second = cal_second + 6'd1;
        end
        else
        begin
            cal_second = 6'd0;
            calendar_minute_step();
        end
    endfunction

    // seconds since year zero, wrapping at 32 bits; day 0 counts as -1 day
    function automatic logic [31:0] calendar_stamp();
        logic [31:0] days;
        days = 32'(cal_year) * 32'd365 + 32'd1
             + ((cal_year == 8'd0) ? 32'd0 : (32'(cal_year) - 32'd1) / 32'd4);
        for (int m = 1; m < cal_month; m++)
        begin
            days += 32'(month_days(cal_year, 4'(m)));
        end
        days = days + 32'(cal_day) - 32'd1;
        return days * SECS_PER_DAY + 32'(cal_hour) * SECS_PER_HOUR
             + 32'(cal_minute) * SECS_PER_MIN + 32'(cal_second);
    endfunction

    function automatic date_rec_t calendar_apply(cal_txn_t t);
        logic [31:0] left;
        if (t.cmd == CMD_SET)
        begin
            cal_year   = t.year;
            cal_month  = t.month;
            cal_day    = t.day;
            cal_hour   = t.hour;
            cal_minute = t.minute;
            cal_second = t.second;
        end
        else
        begin
            left = t.delta;
            while (left >= SECS_PER_DAY)
            begin
                calendar_day_step();
                left -= SECS_PER_DAY;
            end
            while (left >= SECS_PER_HOUR)
            begin
                calendar_hour_step();
                left -= SECS_PER_HOUR;
            end
            while (left >= SECS_PER_MIN)
            begin
                calendar_minute_step();
                left -= SECS_PER_MIN;
            end
            while (left > 0)
            begin
                calendar_second_step();
                left--;
            end
        end
        return {cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second,
                calendar_stamp()};
    endfunction

    function automatic string date_text(date_rec_t d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d ts=%0d",
                         d.year, d.month, d.day, d.hour, d.minute, d.second, d.stamp);
    endfunction

    function automatic cal_txn_t adv_txn(logic [31:0] d);
        cal_txn_t t;
        t       = '0;
        t.cmd   = CMD_ADVANCE;
        t.delta = d;
        return t;
    endfunction

    function automatic cal_txn_t set_txn(logic [7:0] y, logic [3:0] mo, logic [4:0] d,
                                         logic [4:0] h, logic [5:0] mi, logic [5:0] s);
        return {CMD_SET, 32'd0, y, mo, d, h, mi, s};
    endfunction

    function automatic dir_row_t plain_row(cal_txn_t t);
        return {t, 1'b0, ZERO_DATE};
    endfunction

    function automatic dir_row_t typed_row(cal_txn_t t, date_rec_t w);
        return {t, 1'b1, w};
    endfunction

    function automatic cal_txn_t rand_txn();
        cal_txn_t    t;
        int unsigned pick;
        t.year   = 8'($urandom());
        t.month  = 4'($urandom());
        t.day    = 5'($urandom());
        t.hour   = 5'($urandom());
        t.minute = 6'($urandom());
        t.second = 6'($urandom());
        t.delta  = $urandom();
        if ($urandom_range(0, 4) == 0)
        begin
            t.cmd = CMD_SET;
            if ($urandom_range(0, 3) != 0)
            begin
                t.month = 4'($urandom_range(1, 12));
                if ($urandom_range(0, 1) == 0)
                begin
                    t.day    = month_days(t.year, t.month);
                    t.hour   = 5'd23;
                    t.minute = 6'd59;
                    t.second = 6'($urandom_range(45, 59));
                end
                else
                begin
                    t.day    = 5'($urandom_range(1, month_days(t.year, t.month)));
                    t.hour   = 5'($urandom_range(0, 23));
                    t.minute = 6'($urandom_range(0, 59));
                    t.second = 6'($urandom_range(0, 59));
                end
            end
        end
        else
        begin
            t.cmd = CMD_ADVANCE;
            pick  = $urandom_range(0, 99);
            if (pick < 45)
                t.delta = $urandom_range(0, 150);
            else if (pick < 60)
                t.delta = delta_edges[$urandom_range(0, 5)];
            else if (pick < 75)
                t.delta = $urandom_range(0, 7200);
            else if (pick < 88)
                t.delta = $urandom_range(0, 200000);
            else if (pick < 97 || big_jumps >= MAX_BIG_JUMPS)
                t.delta = $urandom_range(0, 86400 * 45);
            else
                big_jumps++;
        end
        return t;
    endfunction

    task automatic issue_txn(input cal_txn_t t);
        start         <= 1'b1;
        cmd           <= t.cmd;
        delta_seconds <= t.delta;
        set_year      <= t.year;
        set_month     <= t.month;
        set_day       <= t.day;
        set_hour      <= t.hour;
        set_minute    <= t.minute;
        set_second    <= t.second;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        date_rec_t got;
        date_rec_t want;
        if (rst_n && done)
        begin
            got = {year_out, month_out, day_out, hour_out, minute_out, second_out, timestamp};
            if (expected_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: got %s", date_text(got));
            end
            else
            begin
                want = expected_dates.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %s, got %s", date_text(want), date_text(got));
                end
            end
        end
    end

    initial
    begin
        dir_row_t  rows[$];
        cal_txn_t  t;
        date_rec_t want;
        int        burst_left;
        int        gap;
        burst_left    = 0;
        start         <= 1'b0;
        cmd           <= CMD_ADVANCE;
        delta_seconds <= '0;
        set_year      <= '0;
        set_month     <= '0;
        set_day       <= '0;
        set_hour      <= '0;
        set_minute    <= '0;
        set_second    <= '0;
        rst_n         <= 1'b0;
        cal_year      = 8'd0;
        cal_month     = 4'd1;
        cal_day       = 5'd1;
        cal_hour      = 5'd0;
        cal_minute    = 6'd0;
        cal_second    = 6'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(typed_row(adv_txn(32'd0), RESET_DATE));
        rows.push_back(plain_row(set_txn(8'd255, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59)));
        rows.push_back(typed_row(adv_txn(32'd1), RESET_DATE));      // year wrap
        rows.push_back(typed_row(set_txn(8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0), ZERO_DATE));
        rows.push_back(plain_row(adv_txn(32'd86400)));              // day 0, month 0
        rows.push_back(plain_row(set_txn(8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63)));
        rows.push_back(typed_row(adv_txn(32'd1), RESET_DATE));      // every field overflows
        rows.push_back(plain_row(set_txn(8'd4, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59)));
        rows.push_back(plain_row(adv_txn(32'd1)));                  // leap Feb 29
        rows.push_back(plain_row(adv_txn(32'd86400)));
        rows.push_back(plain_row(set_txn(8'd3, 4'd2, 5'd28, 5'd12, 6'd0, 6'd0)));
        rows.push_back(plain_row(adv_txn(32'd86400)));
        rows.push_back(plain_row(set_txn(8'd10, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0)));
        rows.push_back(plain_row(adv_txn(32'd86400)));              // day past month end
        rows.push_back(plain_row(set_txn(8'd20, 4'd13, 5'd15, 5'd24, 6'd60, 6'd60)));
        rows.push_back(plain_row(adv_txn(32'd3600)));
        rows.push_back(plain_row(adv_txn(32'd61)));
        rows.push_back(plain_row(set_txn(8'd99, 4'd14, 5'd30, 5'd23, 6'd59, 6'd0)));
        rows.push_back(plain_row(adv_txn(32'd60)));
        rows.push_back(plain_row(adv_txn(32'd86399)));
        rows.push_back(plain_row(adv_txn(32'hFFFF_FFFF)));
        rows.push_back(plain_row(set_txn(8'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0)));
        rows.push_back(plain_row(adv_txn(32'd59)));
        rows.push_back(plain_row(adv_txn(32'd86400 * 366)));

        foreach (rows[i])
        begin
            issue_txn(rows[i].txn);
            want = calendar_apply(rows[i].txn);
            expected_dates.push_back(rows[i].typed ? rows[i].want : want);
            idle_gap($urandom_range(0, 3));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            t = rand_txn();
            issue_txn(t);
            expected_dates.push_back(calendar_apply(t));
            if (n < 40)
            begin
                gap = 0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 10);
                gap        = $urandom_range(1, 12);
            end
            idle_gap(gap);
        end

        start <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== calendar_clock_advance_core.f =====
rtl/cca_pkg.sv
rtl/cca_dp.sv
rtl/cca_ctrl.sv
rtl/calendar_clock_advance_core.sv
tb/testbench.sv
